### src/sit_pkg.sv
// shared types and constants for the segment intersection test pipeline
package sit_pkg;

    // coordinate width of every input field
    localparam int COORD_WIDTH = 32;
    // a coordinate difference needs one bit more than a coordinate
    localparam int DIFF_W      = COORD_WIDTH + 1;
    // exact product of two differences
    localparam int PROD_W      = 2 * DIFF_W;
    // exact difference of two products
    localparam int CROSS_W     = PROD_W + 1;
    // four orientation tests per transaction
    localparam int N_ORIENT    = 4;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;

    // orientation class of a point against a directed segment
    typedef enum logic [1:0] {
        ORIENT_ZERO = 2'd0,
        ORIENT_POS  = 2'd1,
        ORIENT_NEG  = 2'd2
    } orient_t;

    // operands of one cross product: a*b - c*d
    typedef struct packed {
        diff_t a;
        diff_t b;
        diff_t c;
        diff_t d;
    } orient_ops_t;

    // the two products of one cross product
    typedef struct packed {
        prod_t ab;
        prod_t cd;
    } orient_prods_t;

    // output of the difference stage
    typedef struct packed {
        orient_ops_t [N_ORIENT-1:0] ops;
        logic        [N_ORIENT-1:0] in_box;
    } diff_stage_t;

    // output of the product stage
    typedef struct packed {
        orient_prods_t [N_ORIENT-1:0] prods;
        logic          [N_ORIENT-1:0] in_box;
    } mul_stage_t;

    // output of the sign stage
    typedef struct packed {
        orient_t [N_ORIENT-1:0] orient;
        logic    [N_ORIENT-1:0] in_box;
    } sign_stage_t;

endpackage

### src/sit_diff_stage.sv
// first pipeline stage: coordinate differences and bounding-box checks
module sit_diff_stage
    import sit_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  coord_t      p_x,
    input  coord_t      p_y,
    input  coord_t      q_x,
    input  coord_t      q_y,
    input  coord_t      r_x,
    input  coord_t      r_y,
    input  coord_t      s_x,
    input  coord_t      s_y,
    output diff_stage_t stage_reg
);

    diff_stage_t stage_next;

    // operands of orient(a, b, c): (b.y-a.y)*(c.x-b.x) - (c.y-b.y)*(b.x-a.x)
    function automatic orient_ops_t make_ops(coord_t ax, coord_t ay, coord_t bx,
                                             coord_t by, coord_t cx, coord_t cy);
        orient_ops_t o;
        o.a = diff_t'(by) - diff_t'(ay);
        o.b = diff_t'(cx) - diff_t'(bx);
        o.c = diff_t'(cy) - diff_t'(by);
        o.d = diff_t'(bx) - diff_t'(ax);
        return o;
    endfunction

    // point c inside the bounding box of a and b
    function automatic logic box_hit(coord_t ax, coord_t ay, coord_t bx,
                                     coord_t by, coord_t cx, coord_t cy);
        logic x_ok;
        logic y_ok;
        x_ok = ((cx >= ax) && (cx <= bx)) || ((cx >= bx) && (cx <= ax));
        y_ok = ((cy >= ay) && (cy <= by)) || ((cy >= by) && (cy <= ay));
        return x_ok && y_ok;
    endfunction

    // four tests: (p,q,r) (p,q,s) (r,s,p) (r,s,q)
    always_comb
    begin
        stage_next.ops[0]    = make_ops(p_x, p_y, q_x, q_y, r_x, r_y);
        stage_next.ops[1]    = make_ops(p_x, p_y, q_x, q_y, s_x, s_y);
        stage_next.ops[2]    = make_ops(r_x, r_y, s_x, s_y, p_x, p_y);
        stage_next.ops[3]    = make_ops(r_x, r_y, s_x, s_y, q_x, q_y);
        stage_next.in_box[0] = box_hit(p_x, p_y, q_x, q_y, r_x, r_y);
        stage_next.in_box[1] = box_hit(p_x, p_y, q_x, q_y, s_x, s_y);
        stage_next.in_box[2] = box_hit(r_x, r_y, s_x, s_y, p_x, p_y);
        stage_next.in_box[3] = box_hit(r_x, r_y, s_x, s_y, q_x, q_y);
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

### src/sit_mul_stage.sv
// second pipeline stage: eight exact products
module sit_mul_stage
    import sit_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  diff_stage_t stage_in,
    output mul_stage_t  stage_reg
);

    mul_stage_t stage_next;

    // one multiplier per product
    always_comb
    begin
        for (int i = 0; i < N_ORIENT; i++)
        begin
            stage_next.prods[i].ab = stage_in.ops[i].a * stage_in.ops[i].b;
            stage_next.prods[i].cd = stage_in.ops[i].c * stage_in.ops[i].d;
        end
        stage_next.in_box = stage_in.in_box;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

### src/sit_sign_stage.sv
// third pipeline stage: cross product subtraction and sign classification
module sit_sign_stage
    import sit_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  mul_stage_t  stage_in,
    output sign_stage_t stage_reg
);

    sign_stage_t stage_next;
    cross_t      cross_val [N_ORIENT];

    // exact difference of products, then zero / positive / negative
    always_comb
    begin
        for (int i = 0; i < N_ORIENT; i++)
        begin
            cross_val[i] = cross_t'(stage_in.prods[i].ab) - cross_t'(stage_in.prods[i].cd);
            if (cross_val[i] == '0)
            begin
                stage_next.orient[i] = ORIENT_ZERO;
            end
            else if (cross_val[i][CROSS_W-1])
            begin
                stage_next.orient[i] = ORIENT_NEG;
            end
            else
            begin
                stage_next.orient[i] = ORIENT_POS;
            end
        end
        stage_next.in_box = stage_in.in_box;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

### src/segment_intersection_test_core.sv
// top level of the segment intersection test pipeline
// Tests whether two closed 2-D segments, P-Q (first) and R-S (second), share
// any point, touching ends and collinear overlap included. The block is a
// four-stage pipeline: coordinate differences and bounding-box checks, eight
// exact products, cross product sign classification, and the final decision
// in the output register. It takes one transaction per cycle while the
// output side is not stalled; the product stage, one full-width signed
// multiplier per product, sets the clock period. A stall at the output holds
// the output register and each stage with a valid item and no empty stage
// after it, and lets items move on into empty stages.
module segment_intersection_test_core
    import sit_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t first_start_x,
    input  coord_t first_start_y,
    input  coord_t first_end_x,
    input  coord_t first_end_y,
    input  coord_t second_start_x,
    input  coord_t second_start_y,
    input  coord_t second_end_x,
    input  coord_t second_end_y,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   segments_meet
);

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;
    logic        out_valid_reg;
    logic        segments_meet_reg;
    logic        segments_meet_next;
    logic        en1;
    logic        en2;
    logic        en3;
    logic        en_out;
    diff_stage_t s1_data;
    mul_stage_t  s2_data;
    sign_stage_t s3_data;

    // stage enables: a stage loads when it is empty or its content moves on
    assign en_out   = !out_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en_out;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    sit_diff_stage u_diff (
        .clk       (clk),
        .en        (en1),
        .p_x       (first_start_x),
        .p_y       (first_start_y),
        .q_x       (first_end_x),
        .q_y       (first_end_y),
        .r_x       (second_start_x),
        .r_y       (second_start_y),
        .s_x       (second_end_x),
        .s_y       (second_end_y),
        .stage_reg (s1_data)
    );

    sit_mul_stage u_mul (
        .clk       (clk),
        .en        (en2),
        .stage_in  (s1_data),
        .stage_reg (s2_data)
    );

    sit_sign_stage u_sign (
        .clk       (clk),
        .en        (en3),
        .stage_in  (s2_data),
        .stage_reg (s3_data)
    );

    // general crossing, or a collinear endpoint inside the other segment's box
    always_comb
    begin
        segments_meet_next =
            ((s3_data.orient[0] != s3_data.orient[1]) &&
             (s3_data.orient[2] != s3_data.orient[3]))
            || ((s3_data.orient[0] == ORIENT_ZERO) && s3_data.in_box[0])
            || ((s3_data.orient[1] == ORIENT_ZERO) && s3_data.in_box[1])
            || ((s3_data.orient[2] == ORIENT_ZERO) && s3_data.in_box[2])
            || ((s3_data.orient[3] == ORIENT_ZERO) && s3_data.in_box[3]);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            segments_meet_reg <= segments_meet_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign segments_meet = segments_meet_reg;

endmodule

### verif/segment_intersection_test_core_tb.sv
// testbench for the segment intersection test pipeline
`timescale 1ns / 1ps

module segment_intersection_test_core_tb;
    import sit_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1530;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_OFF_LEN   = 250;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t C_MAX = ~C_MIN;

    // one transaction: points P, Q of the first segment and R, S of the second
    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t qx;
        coord_t qy;
        coord_t rx;
        coord_t ry;
        coord_t sx;
        coord_t sy;
    } seg_pair_t;

    // directed row: the flag is typed in only where it is obvious
    typedef struct packed {
        seg_pair_t pair;
        logic      typed;
        logic      meet;
    } vector_row_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY_THIRD
    } rx_mode_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
    logic   out_valid;
    logic   out_ready;
    logic   segments_meet;

    vector_row_t vectors[$];
    logic        meet_expected_q[$];
    logic        meet_wanted;

    int mismatches   = 0;
    int pairs_sent   = 0;
    int results_seen = 0;
    int meets_seen   = 0;
    int hold_offs    = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;

    segment_intersection_test_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_start_x  (first_start_x),
        .first_start_y  (first_start_y),
        .first_end_x    (first_end_x),
        .first_end_y    (first_end_y),
        .second_start_x (second_start_x),
        .second_start_y (second_start_y),
        .second_end_x   (second_end_x),
        .second_end_y   (second_end_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .segments_meet  (segments_meet)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // sign class of (b - a) x (c - b), exact at 128 bits
    function automatic orient_t orientation_of(input longint ax, input longint ay,
                                               input longint bx, input longint by,
                                               input longint cx, input longint cy);
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        logic signed [127:0] cross_val;
        lhs       = (by - ay) * (cx - bx);
        rhs       = (cy - by) * (bx - ax);
        cross_val = lhs - rhs;
        if (cross_val == 0)
            return ORIENT_ZERO;
        else if (cross_val > 0)
            return ORIENT_POS;
        else
            return ORIENT_NEG;
    endfunction

    // point c inside the bounding box of a-b
    function automatic bit within_box(input longint ax, input longint ay,
                                      input longint bx, input longint by,
                                      input longint cx, input longint cy);
        longint xmax;
        longint xmin;
        longint ymax;
        longint ymin;
        xmax = (ax > bx) ? ax : bx;
        xmin = (ax < bx) ? ax : bx;
        ymax = (ay > by) ? ay : by;
        ymin = (ay < by) ? ay : by;
        return (cx <= xmax) && (cx >= xmin) && (cy <= ymax) && (cy >= ymin);
    endfunction

    // do the closed segments P-Q and R-S share a point
    function automatic logic predict_meet(input seg_pair_t pr);
        longint  px, py, qx, qy, rx, ry, sx, sy;
        orient_t o1, o2, o3, o4;
        px = longint'($signed(pr.px));
        py = longint'($signed(pr.py));
        qx = longint'($signed(pr.qx));
        qy = longint'($signed(pr.qy));
        rx = longint'($signed(pr.rx));
        ry = longint'($signed(pr.ry));
        sx = longint'($signed(pr.sx));
        sy = longint'($signed(pr.sy));
        o1 = orientation_of(px, py, qx, qy, rx, ry);
        o2 = orientation_of(px, py, qx, qy, sx, sy);
        o3 = orientation_of(rx, ry, sx, sy, px, py);
        o4 = orientation_of(rx, ry, sx, sy, qx, qy);
        return ((o1 != o2) && (o3 != o4))
            || ((o1 == ORIENT_ZERO) && within_box(px, py, qx, qy, rx, ry))
            || ((o2 == ORIENT_ZERO) && within_box(px, py, qx, qy, sx, sy))
            || ((o3 == ORIENT_ZERO) && within_box(rx, ry, sx, sy, px, py))
            || ((o4 == ORIENT_ZERO) && within_box(rx, ry, sx, sy, qx, qy));
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 6))
            0:       return C_MIN;
            1:       return C_MIN + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return C_MAX - 1;
            default: return C_MAX;
        endcase
    endfunction

    // ~2^20 range, leaves room for offsets without wrapping
    function automatic coord_t mid_coord();
        return $signed($urandom) >>> 11;
    endfunction

    // random pair, mostly shaped to hit collinear, touching and point cases
    function automatic seg_pair_t random_pair();
        seg_pair_t pr;
        int        kind;
        int        bx, by, dx, dy;
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            // full-width noise
            pr = {$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
        end
        else if (kind < 45)
        begin
            // small grid, lots of collinear and touching by chance
            pr.px = int'($urandom_range(0, 16)) - 8;
            pr.py = int'($urandom_range(0, 16)) - 8;
            pr.qx = int'($urandom_range(0, 16)) - 8;
            pr.qy = int'($urandom_range(0, 16)) - 8;
            pr.rx = int'($urandom_range(0, 16)) - 8;
            pr.ry = int'($urandom_range(0, 16)) - 8;
            pr.sx = int'($urandom_range(0, 16)) - 8;
            pr.sy = int'($urandom_range(0, 16)) - 8;
        end
        else if (kind < 65)
        begin
            // all four points on one line, overlap or gap
            bx = $signed($urandom) >>> 2;
            by = $signed($urandom) >>> 2;
            dx = int'($urandom_range(0, 100)) - 50;
            dy = int'($urandom_range(0, 100)) - 50;
            pr.px = bx + (int'($urandom_range(0, 80)) - 40) * dx;
            pr.py = by;
            pr.qx = bx + (int'($urandom_range(0, 80)) - 40) * dx;
            pr.qy = by;
            pr.rx = bx + (int'($urandom_range(0, 80)) - 40) * dx;
            pr.ry = by;
            pr.sx = bx + (int'($urandom_range(0, 80)) - 40) * dx;
            pr.sy = by;
            // same multiples along y keep the points on the line
            pr.py = by + ((pr.px - bx) / ((dx == 0) ? 1 : dx)) * dy;
            pr.qy = by + ((pr.qx - bx) / ((dx == 0) ? 1 : dx)) * dy;
            pr.ry = by + ((pr.rx - bx) / ((dx == 0) ? 1 : dx)) * dy;
            pr.sy = by + ((pr.sx - bx) / ((dx == 0) ? 1 : dx)) * dy;
        end
        else if (kind < 77)
        begin
            // shared endpoint or an end landing mid-segment
            pr = {mid_coord(), mid_coord(), mid_coord(), mid_coord(),
                  mid_coord(), mid_coord(), mid_coord(), mid_coord()};
            case ($urandom_range(0, 4))
                0: {pr.rx, pr.ry} = {pr.px, pr.py};
                1: {pr.rx, pr.ry} = {pr.qx, pr.qy};
                2: {pr.sx, pr.sy} = {pr.px, pr.py};
                3: {pr.sx, pr.sy} = {pr.qx, pr.qy};
                default:
                begin
                    dx = int'($urandom_range(0, 2000)) - 1000;
                    dy = int'($urandom_range(0, 2000)) - 1000;
                    pr.qx = pr.px + 2 * dx;
                    pr.qy = pr.py + 2 * dy;
                    pr.sx = pr.px + dx;
                    pr.sy = pr.py + dy;
                end
            endcase
        end
        else if (kind < 87)
        begin
            // one segment collapsed to a point, on or off the other
            pr.rx = mid_coord();
            pr.ry = mid_coord();
            dx = int'($urandom_range(0, 2000)) - 1000;
            dy = int'($urandom_range(0, 2000)) - 1000;
            pr.sx = pr.rx + 2 * dx;
            pr.sy = pr.ry + 2 * dy;
            if ($urandom_range(0, 1) == 1)
            begin
                pr.px = pr.rx + dx;
                pr.py = pr.ry + dy;
            end
            else
            begin
                pr.px = mid_coord();
                pr.py = mid_coord();
            end
            pr.qx = pr.px;
            pr.qy = pr.py;
            if ($urandom_range(0, 1) == 1)
                pr = {pr.rx, pr.ry, pr.sx, pr.sy, pr.px, pr.py, pr.qx, pr.qy};
        end
        else
        begin
            pr = {extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord()};
        end
        return pr;
    endfunction

    task automatic add_vector(input coord_t px, input coord_t py,
                              input coord_t qx, input coord_t qy,
                              input coord_t rx, input coord_t ry,
                              input coord_t sx, input coord_t sy,
                              input logic typed, input logic meet);
        vector_row_t row;
        row.pair  = {px, py, qx, qy, rx, ry, sx, sy};
        row.typed = typed;
        row.meet  = meet;
        vectors.push_back(row);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // offer one transaction, log its expected flag, then maybe idle
    task automatic send_pair(input seg_pair_t pr, input logic typed, input logic meet);
        int gap;
        in_valid       <= 1'b1;
        first_start_x  <= pr.px;
        first_start_y  <= pr.py;
        first_end_x    <= pr.qx;
        first_end_y    <= pr.qy;
        second_start_x <= pr.rx;
        second_start_y <= pr.ry;
        second_end_x   <= pr.sx;
        second_end_y   <= pr.sy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        meet_expected_q.push_back(typed ? meet : predict_meet(pr));
        pairs_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    // stop offering until every outstanding result is back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (meet_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        first_start_x  <= '0;
        first_start_y  <= '0;
        first_end_x    <= '0;
        first_end_y    <= '0;
        second_start_x <= '0;
        second_start_y <= '0;
        second_end_x   <= '0;
        second_end_y   <= '0;

        // both segments collapsed onto the origin
        add_vector(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
        // proper crossing, and the same with both directions reversed
        add_vector(0, 0, 10, 10, 0, 10, 10, 0, 1'b1, 1'b1);
        add_vector(10, 10, 0, 0, 10, 0, 0, 10, 1'b1, 1'b1);
        // parallel, one apart
        add_vector(0, 0, 10, 0, 0, 1, 10, 1, 1'b1, 1'b0);
        // collinear overlap, collinear with a gap, collinear ends touching
        add_vector(0, 0, 10, 0, 5, 0, 15, 0, 1'b1, 1'b1);
        add_vector(0, 0, 4, 0, 5, 0, 9, 0, 1'b1, 1'b0);
        add_vector(0, 0, 5, 0, 5, 0, 9, 0, 1'b1, 1'b1);
        // shared endpoint at an angle
        add_vector(0, 0, 5, 5, 5, 5, 9, 0, 1'b1, 1'b1);
        // end of the second lies inside the first
        add_vector(0, 0, 10, 0, 5, 0, 5, 7, 1'b1, 1'b1);
        // second stops short of the first
        add_vector(0, 0, 10, 10, 0, 10, 4, 5, 1'b1, 1'b0);
        // point segment on the other segment, and just off it
        add_vector(3, 3, 3, 3, 0, 0, 6, 6, 1'b1, 1'b1);
        add_vector(3, 4, 3, 4, 0, 0, 6, 6, 1'b1, 1'b0);
        // two point segments, apart and coincident
        add_vector(1, 1, 1, 1, 2, 2, 2, 2, 1'b1, 1'b0);
        add_vector(-7, 9, -7, 9, -7, 9, -7, 9, 1'b1, 1'b1);
        // diagonals and opposite edges of the full coordinate square
        add_vector(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 1'b1);
        add_vector(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1, 1'b0);
        // short piece of the main diagonal, and a point just off it
        add_vector(C_MIN, C_MIN, C_MAX, C_MAX, -1, -1, 0, 0, 1'b1, 1'b1);
        add_vector(C_MIN, C_MIN, C_MAX, C_MAX, 0, 1, 0, 1, 1'b1, 1'b0);
        // every coordinate at one extreme
        add_vector(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1);
        add_vector(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, 1'b1);
        // large mixed values, left to the predictor
        add_vector(C_MAX, C_MIN, C_MIN, C_MAX, 32'h5555_5555, 32'haaaa_aaaa,
                   32'haaaa_aaaa, 32'h5555_5555, 1'b0, 1'b0);
        add_vector(C_MIN + 1, C_MAX, C_MAX - 1, C_MIN, 0, C_MIN, 1, C_MAX, 1'b0, 1'b0);
        add_vector(32'h1234_5678, -32'h0765_4321, -32'h7000_0000, 32'h6fff_ffff,
                   32'h0000_ffff, C_MIN, -32'h0000_ffff, C_MAX, 1'b0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            send_pair(vectors[i].pair, vectors[i].typed, vectors[i].meet);
        wait_all_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_all_results();
            send_pair(random_pair(), 1'b0, 1'b0);
        end
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d segment pairs sent (%0d directed), %0d results checked, %0d meeting",
                 pairs_sent, vectors.size(), results_seen, meets_seen);
        $display("mix: noise, grid, collinear, shared ends, point segments, extremes; %0d %s",
                 hold_offs, "long receiver hold-offs");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver: stall patterns in windows, with a long hold-off now and then
    initial
    begin
        rx_mode_t mode;
        int       window;
        int       len;
        out_ready <= 1'b0;
        window = 0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (window % 12 == 5)
            begin
                hold_offs++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(32, 96);
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= (k % 3 == 0);
                endcase
                @(posedge clk);
            end
            window++;
        end
    end

    // compare each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (meet_expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %b with nothing outstanding",
                                          segments_meet));
            end
            else
            begin
                meet_wanted = meet_expected_q.pop_front();
                if (segments_meet !== meet_wanted)
                    report_mismatch($sformatf("result %0d: segments_meet %b, wanted %b",
                                              results_seen, segments_meet, meet_wanted));
                results_seen++;
                if (meet_wanted)
                    meets_seen++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

endmodule

### sim.f
src/sit_pkg.sv
src/sit_diff_stage.sv
src/sit_mul_stage.sv
src/sit_sign_stage.sv
src/segment_intersection_test_core.sv
verif/segment_intersection_test_core_tb.sv
